>>> hw/rtl/clst_pkg.sv
// ----------------------------------------------------------------------------
// clst_pkg
// Shared types and constants for the cursor list engine.
// ----------------------------------------------------------------------------
package clst_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = 6;
    localparam int OP_W        = 4;
    localparam int STAT_W      = 3;
    localparam int IN_FIELDS_W = DATA_WIDTH + POS_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_WIDTH + ADDR_W + CNT_W + ADDR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 4'd0,
        OP_APPEND = 4'd1,
        OP_ERASE  = 4'd2,
        OP_BEGIN  = 4'd3,
        OP_END    = 4'd4,
        OP_PREV   = 4'd5,
        OP_NEXT   = 4'd6,
        OP_SETPOS = 4'd7,
        OP_READ   = 4'd8,
        OP_FIND   = 4'd9,
        OP_CLEAR  = 4'd10
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // start/stop for the address walker
    typedef struct packed {
        logic              start;
        logic              down;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic              stop;
    } t_walk_cmd;

    // walker read port and returned-data tag
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              dv;
        logic [ADDR_W-1:0] da;
        logic              busy;
    } t_walk_sts;

endpackage

>>> hw/rtl/clst_ram.sv
// ----------------------------------------------------------------------------
// clst_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clst_ram (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [clst_pkg::ADDR_W-1:0]     i_waddr,
    input  logic [clst_pkg::DATA_WIDTH-1:0] i_wdata,
    input  logic                            i_re,
    input  logic [clst_pkg::ADDR_W-1:0]     i_raddr,
    output logic [clst_pkg::DATA_WIDTH-1:0] o_rdata
);
    import clst_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/clst_walk.sv
// ----------------------------------------------------------------------------
// clst_walk
// Address walker: issues one read per cycle up or down through the store
// and tags the returning data with its address.
// ----------------------------------------------------------------------------
module clst_walk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  clst_pkg::t_walk_cmd   i_cmd,
    output clst_pkg::t_walk_sts   o_sts
);
    import clst_pkg::*;

    logic [ADDR_W-1:0] r_ra;
    logic [CNT_W-1:0]  r_rem;
    logic              r_down;
    logic              r_dv;
    logic [ADDR_W-1:0] r_da;
    logic              rd_en;

    assign rd_en = (r_rem != '0) && !i_cmd.stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_dv   <= 1'b0;
            r_down <= 1'b0;
        end else if (i_cmd.start) begin
            r_ra   <= i_cmd.addr;
            r_rem  <= i_cmd.count;
            r_down <= i_cmd.down;
            r_dv   <= 1'b0;
        end else if (i_cmd.stop) begin
            r_rem <= '0;
            r_dv  <= 1'b0;
        end else begin
            r_dv <= rd_en;
            r_da <= r_ra;
            if (rd_en) begin
                r_rem <= r_rem - CNT_W'(1);
                r_ra  <= r_down ? r_ra - ADDR_W'(1) : r_ra + ADDR_W'(1);
            end
        end
    end

    always_comb begin
        o_sts.rd_en   = rd_en;
        o_sts.rd_addr = r_ra;
        o_sts.dv      = r_dv;
        o_sts.da      = r_da;
        o_sts.busy    = (r_rem != '0) || r_dv;
    end

endmodule

>>> hw/rtl/cursor_list_engine_core.sv
// Path, input beat to result beat: cursor moves, clear, unused codes, rejected ops and
// find on an empty list go straight to the result; append, and insert at the end of the
// list, write the store in S_PUT; read, erase and find walk the store in S_SWEEP; insert
// elsewhere walks in S_SWEEP, then writes in S_PUT. Throughput: one item at a time;
// the walk through the store, at one entry per cycle, sets the pace.
// Reset (i_rst_n low, synchronous): size and cursor to 0, block idle.
// ----------------------------------------------------------------------------
// cursor_list_engine_core
// Ordered list with a cursor: insert, append, erase, cursor moves, read, find
// and clear, driven by a small sequencer around a shared memory walker.
// ----------------------------------------------------------------------------
module cursor_list_engine_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value [31:0], position [37:32], zero pad
    input  logic [clst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation [3:0]
    input  logic [clst_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_value [31:0], found_index [37:32], list_size [44:38],
    // cursor [50:45], zero pad
    output logic [clst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status [2:0]
    output logic [clst_pkg::STAT_W-1:0]      m_axis_tuser
);
    import clst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_PUT,
        S_OUT
    } t_state;

    t_state                r_state;
    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_cursor;
    logic [ADDR_W-1:0]     r_put_addr;
    logic [DATA_WIDTH-1:0] r_rval;
    logic [ADDR_W-1:0]     r_fidx;
    t_status               r_st;

    logic                  accept;
    t_op                   in_op;
    logic [DATA_WIDTH-1:0] in_val;
    logic [POS_W-1:0]      in_pos;
    logic                  is_full;
    logic                  is_empty;
    logic                  cur_lt_cnt;
    logic                  cur_gt_cnt;
    logic [CNT_W-1:0]      tail_len;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  match;

    t_walk_cmd             walk_cmd;
    t_walk_sts             walk_sts;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rq;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign in_op      = t_op'(s_axis_tuser);
    assign in_val     = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_pos     = s_axis_tdata[DATA_WIDTH +: POS_W];
    assign is_full    = (r_count == CNT_W'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign cur_lt_cnt = ({1'b0, r_cursor} < r_count);
    assign cur_gt_cnt = ({1'b0, r_cursor} > r_count);
    assign tail_len   = r_count - {1'b0, r_cursor};
    assign cnt_dec    = r_count - CNT_W'(1);
    assign match      = walk_sts.dv && (rq == r_val);

    clst_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (walk_cmd),
        .o_sts   (walk_sts)
    );

    clst_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (walk_sts.rd_en),
        .i_raddr (walk_sts.rd_addr),
        .o_rdata (rq)
    );

    // walker start on accept, early stop on the first find hit
    always_comb begin
        walk_cmd = '0;
        if (r_state == S_IDLE && accept) begin
            unique case (in_op)
                OP_INSERT: begin
                    // shift the tail up, from the last entry down to the cursor
                    walk_cmd.start = !is_full && cur_lt_cnt;
                    walk_cmd.down  = 1'b1;
                    walk_cmd.addr  = cnt_dec[ADDR_W-1:0];
                    walk_cmd.count = tail_len;
                end
                OP_ERASE: begin
                    walk_cmd.start = cur_lt_cnt;
                    walk_cmd.addr  = r_cursor;
                    walk_cmd.count = tail_len;
                end
                OP_READ: begin
                    walk_cmd.start = cur_lt_cnt;
                    walk_cmd.addr  = r_cursor;
                    walk_cmd.count = CNT_W'(1);
                end
                OP_FIND: begin
                    walk_cmd.start = !is_empty;
                    walk_cmd.count = r_count;
                end
                default: begin
                    walk_cmd.start = 1'b0;
                end
            endcase
        end else if (r_state == S_SWEEP) begin
            walk_cmd.stop = (r_op == OP_FIND) && match;
        end
    end

    // store writes: shifted entries during the walk, new value in S_PUT
    always_comb begin
        we    = 1'b0;
        waddr = r_put_addr;
        wdata = r_val;
        if (r_state == S_PUT) begin
            we = 1'b1;
        end else if (r_state == S_SWEEP && walk_sts.dv) begin
            wdata = rq;
            if (r_op == OP_INSERT) begin
                we    = 1'b1;
                waddr = walk_sts.da + ADDR_W'(1);
            end else if (r_op == OP_ERASE && walk_sts.da != r_cursor) begin
                we    = 1'b1;
                waddr = walk_sts.da - ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_op     <= OP_BEGIN;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= in_op;
                        r_val   <= in_val;
                        r_rval  <= '0;
                        r_fidx  <= '0;
                        r_st    <= ST_OK;
                        r_state <= S_OUT;
                        unique case (in_op)
                            OP_INSERT: begin
                                r_put_addr <= r_cursor;
                                if (is_full) begin
                                    r_st <= ST_FULL;
                                end else if (cur_gt_cnt) begin
                                    r_st <= ST_BADPOS;
                                end else if (cur_lt_cnt) begin
                                    r_state <= S_SWEEP;
                                end else begin
                                    r_state <= S_PUT;
                                end
                            end
                            OP_APPEND: begin
                                r_put_addr <= r_count[ADDR_W-1:0];
                                if (is_full) begin
                                    r_st <= ST_FULL;
                                end else begin
                                    r_state <= S_PUT;
                                end
                            end
                            OP_ERASE, OP_READ: begin
                                if (is_empty) begin
                                    r_st <= ST_EMPTY;
                                end else if (!cur_lt_cnt) begin
                                    r_st <= ST_BADPOS;
                                end else begin
                                    r_state <= S_SWEEP;
                                end
                            end
                            OP_BEGIN: begin
                                r_cursor <= '0;
                            end
                            OP_END: begin
                                if (is_empty) begin
                                    r_cursor <= '0;
                                    r_st     <= ST_EMPTY;
                                end else begin
                                    r_cursor <= cnt_dec[ADDR_W-1:0];
                                end
                            end
                            OP_PREV: begin
                                if (r_cursor != '0) begin
                                    r_cursor <= r_cursor - ADDR_W'(1);
                                end
                            end
                            OP_NEXT: begin
                                if (({1'b0, r_cursor} + CNT_W'(1)) < r_count) begin
                                    r_cursor <= r_cursor + ADDR_W'(1);
                                end
                            end
                            OP_SETPOS: begin
                                if (CNT_W'(in_pos) > r_count) begin
                                    r_st <= ST_BADPOS;
                                end else begin
                                    r_cursor <= in_pos[ADDR_W-1:0];
                                end
                            end
                            OP_FIND: begin
                                r_st <= ST_NOTFOUND;
                                if (!is_empty) begin
                                    r_state <= S_SWEEP;
                                end
                            end
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_cursor <= '0;
                            end
                            default: begin
                                r_st <= ST_OK;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    if (walk_sts.dv) begin
                        if ((r_op == OP_ERASE && walk_sts.da == r_cursor)
                            || r_op == OP_READ) begin
                            r_rval <= rq;
                        end
                        if (r_op == OP_FIND && match) begin
                            r_fidx <= walk_sts.da;
                            r_st   <= ST_OK;
                        end
                    end
                    if (!walk_sts.busy) begin
                        if (r_op == OP_INSERT) begin
                            r_state <= S_PUT;
                        end else begin
                            r_state <= S_OUT;
                        end
                        if (r_op == OP_ERASE) begin
                            r_count <= cnt_dec;
                            // pull the cursor back inside the shorter list
                            if (cnt_dec == '0) begin
                                r_cursor <= '0;
                            end else if ({1'b0, r_cursor} >= cnt_dec) begin
                                r_cursor <= r_cursor - ADDR_W'(1);
                            end
                        end
                    end
                end
                S_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = OUT_TDATA_W'({r_cursor, r_count, r_fidx, r_rval});
    assign m_axis_tuser  = r_st;

    // one item in flight: input side closed while a result beat waits
    a_no_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while result beat pending");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after accepting a beat");

    a_size_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list size beyond capacity");

    a_cursor_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cursor} <= r_count)
        else $error("cursor beyond list size");

endmodule
